// ----- src/eti_pkg.sv -----
// ----------------------------------------------------------------------------
// Eased tween interpolator package
// Field widths, command and curve codes, and the beat types of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package eti_pkg;

  localparam int VALUE_BITS = 32;
  localparam int TIME_BITS  = 32;

  typedef enum logic [1:0] {
    FUNC_SET     = 2'd0,
    FUNC_RUN     = 2'd1,
    FUNC_TOWARD  = 2'd2,
    FUNC_ADVANCE = 2'd3
  } func_t;

  localparam logic [1:0] CURVE_LINEAR    = 2'd0;
  localparam logic [1:0] CURVE_CUBIC_OUT = 2'd1;
  localparam logic [1:0] CURVE_BACK_OUT  = 2'd2;

  typedef struct packed {
    func_t                        func;
    logic signed [VALUE_BITS-1:0] target_value;
    logic [TIME_BITS-1:0]         now_ticks;
    logic [TIME_BITS-1:0]         duration_ticks;
    logic [1:0]                   curve_kind;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] current_value;
    logic                         is_running;
  } res_t;

endpackage

`default_nettype wire

// ----- src/eased_tween_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// Eased tween interpolator
// Holds one animated Q16.16 value and runs set, run, toward and advance
// commands with linear, cubic out or back out easing.
// ----------------------------------------------------------------------------
// Each command beat gives exactly one result beat. Set, run and toward go
// through the decode and done states to the result register, and done waits
// while an earlier result is still held. Advance of a running move also
// runs a restoring divider, which retires one fraction bit per cycle, and
// uses a single 32 by (FRACTION_BITS + 2) multiplier, registered at its
// output, which is reused for the easing polynomial and the final scaling.
// The command port is ready only while the sequencer is idle; a finished
// result may still wait in the output register then.
`default_nettype none

module eased_tween_interpolator_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire eti_pkg::cmd_t cmd_data,
  output logic               res_valid,
  input  wire logic          res_ready,
  output eti_pkg::res_t      res_data
);

  localparam int V      = eti_pkg::VALUE_BITS;
  localparam int T      = eti_pkg::TIME_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int M_W    = F + 1;
  localparam int E_W    = F + 2;
  localparam int MA_W   = 32;
  localparam int PROD_W = MA_W + E_W;
  localparam int NCH    = (V + MA_W - 1) / MA_W;
  localparam int MAG_W  = NCH * MA_W;
  localparam int ACC_W  = MAG_W + E_W;
  localparam int AMT_W  = ACC_W - F + 1;
  localparam int CNT_W  = $clog2(F + NCH + 1);

  localparam logic [63:0] OVER_L = ((64'd170158 << F) + 64'd50000) / 64'd100000;
  localparam logic [MA_W-1:0] OVER  = MA_W'(OVER_L);
  localparam logic [MA_W-1:0] OVER1 = MA_W'(OVER_L + (64'd1 << F));
  localparam logic [E_W-1:0]  ONE_E = {2'b01, {F{1'b0}}};
  localparam logic [M_W-1:0]  ONE_M = {1'b1, {F{1'b0}}};
  localparam logic [PROD_W:0] HALF_P = {{(PROD_W - F + 1){1'b0}}, 1'b1, {(F - 1){1'b0}}};
  localparam logic [ACC_W:0]  HALF_A = {{(ACC_W - F + 1){1'b0}}, 1'b1, {(F - 1){1'b0}}};
  localparam logic signed [V-1:0] VMAX = {1'b0, {(V - 1){1'b1}}};
  localparam logic signed [V-1:0] VMIN = {1'b1, {(V - 1){1'b0}}};

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_DIV, S_EASE, S_M2, S_M2W, S_M3, S_M3W,
    S_B1, S_B1W, S_B2, S_B2W, S_SETUP, S_SC_MUL, S_SC_ACC, S_ROUND,
    S_FINAL, S_DONE
  } state_t;

  state_t               state;
  eti_pkg::cmd_t        cmd_q;
  logic signed [V-1:0]  present;
  logic signed [V-1:0]  origin;
  logic signed [V-1:0]  dest;
  logic [T-1:0]         start;
  logic [T-1:0]         span;
  logic [1:0]           curve;
  logic                 moving;

  logic [T-1:0]         rem;
  logic [F-1:0]         q;
  logic [CNT_W-1:0]     cnt;
  logic [M_W-1:0]       m;
  logic [M_W-1:0]       m2;
  logic [M_W-1:0]       m3;
  logic [E_W-1:0]       tmp;
  logic [E_W-1:0]       e;
  logic                 neg;
  logic [V-1:0]         limit;
  logic [MAG_W-1:0]     mag_sh;
  logic [ACC_W-1:0]     acc;
  logic [AMT_W-1:0]     amount;
  logic [PROD_W-1:0]    prod;

  logic [MA_W-1:0]      mul_a;
  logic [E_W-1:0]       mul_b;
  logic [PROD_W:0]      rnd;
  logic [E_W-1:0]       rmul_val;
  logic [T-1:0]         elapsed;
  logic [T:0]           r2;
  logic                 ge;
  logic                 skip;
  logic [V:0]           diff;
  logic [V:0]           mag_full;
  logic [V:0]           lim_full;
  logic [E_W:0]         sum_b;
  logic [ACC_W:0]       acc_rnd;

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_M2: begin
        mul_a = MA_W'(m);
        mul_b = E_W'(m);
      end
      S_M3: begin
        mul_a = MA_W'(m2);
        mul_b = E_W'(m);
      end
      S_B1: begin
        mul_a = OVER1;
        mul_b = E_W'(m3);
      end
      S_B2: begin
        mul_a = OVER;
        mul_b = E_W'(m2);
      end
      S_SC_MUL: begin
        mul_a = mag_sh[MAG_W-1 -: MA_W];
        mul_b = e;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rnd      = {1'b0, prod} + HALF_P;
    rmul_val = rnd[F +: E_W];
    elapsed  = cmd_q.now_ticks - start;
    r2       = {rem, 1'b0};
    ge       = (r2 >= {1'b0, span});
    skip     = moving ? (dest == cmd_q.target_value) : (present == cmd_q.target_value);
    diff     = {dest[V-1], dest} - {origin[V-1], origin};
    mag_full = diff[V] ? (~diff + 1'b1) : diff;
    lim_full = diff[V] ? ({origin[V-1], origin} - {1'b1, VMIN})
                       : ({1'b0, VMAX} - {origin[V-1], origin});
    sum_b    = {1'b0, ONE_E} + {1'b0, rmul_val};
    acc_rnd  = {1'b0, acc} + HALF_A;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      present   <= '0;
      origin    <= '0;
      dest      <= '0;
      start     <= '0;
      span      <= '0;
      curve     <= eti_pkg::CURVE_LINEAR;
      moving    <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd_data;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_DONE;
          case (cmd_q.func)
            eti_pkg::FUNC_SET: begin
              present <= cmd_q.target_value;
              origin  <= cmd_q.target_value;
              dest    <= cmd_q.target_value;
              moving  <= 1'b0;
            end
            eti_pkg::FUNC_RUN, eti_pkg::FUNC_TOWARD: begin
              if (cmd_q.func == eti_pkg::FUNC_RUN || !skip) begin
                if (cmd_q.duration_ticks == '0) begin
                  present <= cmd_q.target_value;
                  origin  <= cmd_q.target_value;
                  dest    <= cmd_q.target_value;
                  moving  <= 1'b0;
                end else begin
                  origin <= present;
                  dest   <= cmd_q.target_value;
                  start  <= cmd_q.now_ticks;
                  span   <= cmd_q.duration_ticks;
                  curve  <= cmd_q.curve_kind;
                  moving <= 1'b1;
                end
              end
            end
            default: begin
              if (moving) begin
                if (elapsed >= span) begin
                  present <= dest;
                  moving  <= 1'b0;
                end else begin
                  rem   <= elapsed;
                  q     <= '0;
                  cnt   <= CNT_W'(F);
                  state <= S_DIV;
                end
              end
            end
          endcase
        end
        S_DIV: begin
          rem <= ge ? T'(r2 - {1'b0, span}) : r2[T-1:0];
          q   <= {q[F-2:0], ge};
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= S_EASE;
          end
        end
        S_EASE: begin
          if (q == '0) begin
            e     <= '0;
            state <= S_SETUP;
          end else if (curve != eti_pkg::CURVE_CUBIC_OUT &&
                       curve != eti_pkg::CURVE_BACK_OUT) begin
            e     <= E_W'(q);
            state <= S_SETUP;
          end else begin
            m     <= ONE_M - M_W'(q);
            state <= S_M2;
          end
        end
        S_M2: state <= S_M2W;
        S_M2W: begin
          m2    <= rmul_val[M_W-1:0];
          state <= S_M3;
        end
        S_M3: state <= S_M3W;
        S_M3W: begin
          m3 <= rmul_val[M_W-1:0];
          if (curve == eti_pkg::CURVE_CUBIC_OUT) begin
            e     <= ONE_E - rmul_val;
            state <= S_SETUP;
          end else begin
            state <= S_B1;
          end
        end
        S_B1: state <= S_B1W;
        S_B1W: begin
          tmp   <= rmul_val;
          state <= S_B2;
        end
        S_B2: state <= S_B2W;
        S_B2W: begin
          e     <= (sum_b < {1'b0, tmp}) ? '0 : E_W'(sum_b - {1'b0, tmp});
          state <= S_SETUP;
        end
        S_SETUP: begin
          neg    <= diff[V];
          limit  <= lim_full[V-1:0];
          mag_sh <= MAG_W'(mag_full[V-1:0]);
          acc    <= '0;
          cnt    <= CNT_W'(NCH);
          state  <= S_SC_MUL;
        end
        S_SC_MUL: begin
          mag_sh <= mag_sh << MA_W;
          state  <= S_SC_ACC;
        end
        S_SC_ACC: begin
          acc <= (acc << MA_W) + ACC_W'(prod);
          cnt <= cnt - 1'b1;
          state <= (cnt == CNT_W'(1)) ? S_ROUND : S_SC_MUL;
        end
        S_ROUND: begin
          amount <= acc_rnd[ACC_W:F];
          state  <= S_FINAL;
        end
        S_FINAL: begin
          if (amount > AMT_W'(limit)) begin
            present <= neg ? VMIN : VMAX;
          end else if (neg) begin
            present <= origin - amount[V-1:0];
          end else begin
            present <= origin + amount[V-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid              <= 1'b1;
            res_data.current_value <= present;
            res_data.is_running    <= moving;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command port stayed ready after a beat was taken");

  a_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    moving |-> span != '0)
    else $error("a move is running with a zero span");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < span)
    else $error("divider remainder reached the span");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!res_valid || res_ready) |=> res_valid && cmd_ready)
    else $error("finished command did not post a result beat");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Eased tween interpolator testbench
// Sends set, run, toward and advance beats, first hand-picked corner cases and
// then random moves with follow-up advances under several idle and stall
// mixes. A predictor of the animated value checks every result beat.
// ----------------------------------------------------------------------------
module testbench;

  typedef longint unsigned u64_t;
  typedef logic signed [eti_pkg::VALUE_BITS-1:0] value_t;
  typedef logic [eti_pkg::TIME_BITS-1:0] ticks_t;

  localparam int FRAC = 16;
  localparam u64_t ONE_Q = u64_t'(1) << FRAC;
  localparam u64_t HALF_Q = u64_t'(1) << (FRAC - 1);
  localparam u64_t OVER_Q = ((u64_t'(170158) << FRAC) + u64_t'(50000)) / u64_t'(100000);
  localparam u64_t OVER1_Q = OVER_Q + ONE_Q;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam logic [1:0] CURVE_ALT_LINEAR = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int BACKLOG_HOLD = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  eti_pkg::cmd_t cmd_data = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  eti_pkg::res_t res_data;

  value_t tween_value, tween_origin, tween_dest;
  ticks_t tween_start, tween_span;
  logic [1:0] tween_curve;
  logic tween_moving;

  eti_pkg::res_t expected_results[$];
  int error_count = 0;
  int idle_cycles = 0;
  int sent_beats = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_stretch = 0;

  eased_tween_interpolator_unit #(.FRACTION_BITS(FRAC)) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_data(cmd_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data(res_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic u64_t round_mul(u64_t a, u64_t b);
    return (a * b + HALF_Q) >> FRAC;
  endfunction

  function automatic u64_t eased_fraction(logic [1:0] curve, u64_t t);
    u64_t m, m2, m3;
    longint e;
    if (t == 0) return 0;
    if (curve != eti_pkg::CURVE_CUBIC_OUT && curve != eti_pkg::CURVE_BACK_OUT) return t;
    m = ONE_Q - t;
    m2 = round_mul(m, m);
    m3 = round_mul(m2, m);
    if (curve == eti_pkg::CURVE_CUBIC_OUT) return ONE_Q - m3;
    e = longint'(ONE_Q) - longint'(round_mul(OVER1_Q, m3)) + longint'(round_mul(OVER_Q, m2));
    return (e < 0) ? 0 : u64_t'(e);
  endfunction

  function automatic u64_t elapsed_fraction(u64_t r, u64_t span);
    u64_t q, gap;
    q = 0;
    for (int i = 0; i < FRAC; i++) begin
      gap = span - r;
      if (r >= gap) begin
        q = (q << 1) | 1;
        r = r - gap;
      end else begin
        q = q << 1;
        r = r + r;
      end
    end
    return q;
  endfunction

  function automatic value_t tween_position(u64_t e);
    longint org, dst, amount;
    org = tween_origin;
    dst = tween_dest;
    if (dst >= org) begin
      amount = longint'((u64_t'(dst - org) * e + HALF_Q) >> FRAC);
      if (amount > VMAX - org) return value_t'(VMAX);
      return value_t'(org + amount);
    end
    amount = longint'((u64_t'(org - dst) * e + HALF_Q) >> FRAC);
    if (amount > org - VMIN) return value_t'(VMIN);
    return value_t'(org - amount);
  endfunction

  function automatic void jump_to(value_t v);
    tween_value = v;
    tween_origin = v;
    tween_dest = v;
    tween_moving = 1'b0;
  endfunction

  function automatic void start_move(eti_pkg::cmd_t c);
    if (c.duration_ticks == 0) begin
      jump_to(c.target_value);
    end else begin
      tween_origin = tween_value;
      tween_dest = c.target_value;
      tween_start = c.now_ticks;
      tween_span = c.duration_ticks;
      tween_curve = c.curve_kind;
      tween_moving = 1'b1;
    end
  endfunction

  function automatic eti_pkg::res_t predict_result(eti_pkg::cmd_t c);
    ticks_t elapsed;
    eti_pkg::res_t r;
    case (c.func)
      eti_pkg::FUNC_SET: begin
        jump_to(c.target_value);
      end
      eti_pkg::FUNC_RUN: begin
        start_move(c);
      end
      eti_pkg::FUNC_TOWARD: begin
        if (tween_moving ? tween_dest != c.target_value : tween_value != c.target_value)
          start_move(c);
      end
      default: begin
        if (tween_moving) begin
          elapsed = c.now_ticks - tween_start;
          if (tween_span == 0 || elapsed >= tween_span) begin
            tween_value = tween_dest;
            tween_moving = 1'b0;
          end else begin
            tween_value = tween_position(
                eased_fraction(tween_curve, elapsed_fraction(elapsed, tween_span)));
          end
        end
      end
    endcase
    r.current_value = tween_value;
    r.is_running = tween_moving;
    return r;
  endfunction

  always @(posedge clk) begin
    eti_pkg::res_t want;
    if (rst) begin
      tween_value = '0;
      tween_origin = '0;
      tween_dest = '0;
      tween_start = '0;
      tween_span = '0;
      tween_curve = eti_pkg::CURVE_LINEAR;
      tween_moving = 1'b0;
      idle_cycles = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result beat %h arrived with nothing expected", $time, res_data);
        end else begin
          want = expected_results.pop_front();
          if (res_data.current_value !== want.current_value) begin
            error_count++;
            $display("%0t: current_value expected %h, got %h", $time,
                     want.current_value, res_data.current_value);
          end
          if (res_data.is_running !== want.is_running) begin
            error_count++;
            $display("%0t: is_running expected %b, got %b", $time,
                     want.is_running, res_data.is_running);
          end
        end
      end
      if (cmd_valid && cmd_ready) expected_results.push_back(predict_result(cmd_data));
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_stretch > 0) begin
      res_ready <= 1'b0;
      hold_stretch--;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  function automatic eti_pkg::cmd_t make_cmd(eti_pkg::func_t f, value_t v, ticks_t now,
                                             ticks_t dur, logic [1:0] curve);
    eti_pkg::cmd_t c;
    c.func = f;
    c.target_value = v;
    c.now_ticks = now;
    c.duration_ticks = dur;
    c.curve_kind = curve;
    return c;
  endfunction

  function automatic value_t random_target();
    if ($urandom_range(0, 1) == 0) return $urandom();
    return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
  endfunction

  task automatic send_cmd(eti_pkg::cmd_t c);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
    sent_beats++;
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_traffic(int send_pct, int stall_pct, int hold);
    @(posedge clk);
    sender_idle_pct = send_pct;
    receiver_stall_pct = stall_pct;
    hold_stretch = hold;
    @(negedge clk);
  endtask

  task automatic random_move();
    ticks_t now, span;
    value_t target;
    eti_pkg::func_t f;
    int steps;
    case ($urandom_range(0, 19))
      17: span = '0;
      18, 19: span = $urandom();
      14, 15, 16: span = $urandom_range(1, 8);
      default: span = $urandom_range(1, 2000);
    endcase
    now = $urandom();
    target = random_target();
    f = ($urandom_range(0, 9) < 7) ? eti_pkg::FUNC_RUN : eti_pkg::FUNC_TOWARD;
    if (f == eti_pkg::FUNC_TOWARD && $urandom_range(0, 3) == 0)
      target = tween_moving ? tween_dest : tween_value;
    send_cmd(make_cmd(f, target, now, span, 2'($urandom_range(0, 3))));
    steps = $urandom_range(1, 6);
    repeat (steps) begin
      if ($urandom_range(0, 9) == 0) now = $urandom();
      else now = now + $urandom_range(0, span / 4 + 1);
      send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, $urandom(), now, $urandom(),
                        2'($urandom_range(0, 3))));
    end
  endtask

  task automatic test_directed_cases();
    send_cmd(make_cmd(eti_pkg::FUNC_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      CURVE_ALT_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_SET, 32'h8000_0000, '0, '0, eti_pkg::CURVE_LINEAR));
    // An advance while idle only reports the present value.
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'hFFFF_FFFF, '0, eti_pkg::CURVE_BACK_OUT));
    send_cmd(make_cmd(eti_pkg::FUNC_SET, '0, '0, '0, eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_RUN, 32'h0064_0000, 32'h10, 32'd1000,
                      eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'h10, '0, eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'h10 + 32'd500, '0, eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'h10 + 32'd999, '0, eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'h10 + 32'd1000, '0,
                      eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_RUN, 32'h8000_0000, 32'hFFFF_FF00, 32'hFFFF_FFFF,
                      eti_pkg::CURVE_CUBIC_OUT));
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'h7FFF_FF00, '0, eti_pkg::CURVE_LINEAR));
    // Toward the current destination while moving is skipped.
    send_cmd(make_cmd(eti_pkg::FUNC_TOWARD, 32'h8000_0000, '0, 32'd5, eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'hFFFF_FEFF, '0, eti_pkg::CURVE_LINEAR));
    // Toward the present value while idle is skipped too.
    send_cmd(make_cmd(eti_pkg::FUNC_TOWARD, 32'h8000_0000, '0, 32'd5, eti_pkg::CURVE_LINEAR));
    // Back out overshoot past both ends of the value range saturates.
    send_cmd(make_cmd(eti_pkg::FUNC_SET, 32'h7FFF_FFFF, '0, '0, eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_RUN, 32'h8000_0000, '0, 32'd100,
                      eti_pkg::CURVE_BACK_OUT));
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'd60, '0, eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_SET, 32'h8000_0000, '0, '0, eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_RUN, 32'h7FFF_FFFF, 32'd1000, 32'd100,
                      eti_pkg::CURVE_BACK_OUT));
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'd1050, '0, eti_pkg::CURVE_LINEAR));
    // A time before the start wraps to a large elapsed count and ends the move.
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'd999, '0, eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_RUN, 32'h1234_5678, 32'd5, 32'd7, CURVE_ALT_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'd8, '0, eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_RUN, 32'hFEDC_BA98, '0, '0, eti_pkg::CURVE_CUBIC_OUT));
    send_cmd(make_cmd(eti_pkg::FUNC_TOWARD, 32'h0001_0000, '0, 32'd3,
                      eti_pkg::CURVE_BACK_OUT));
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'd1, '0, eti_pkg::CURVE_LINEAR));
    send_cmd(make_cmd(eti_pkg::FUNC_ADVANCE, '0, 32'd2, '0, eti_pkg::CURVE_LINEAR));
    wait_drained();
  endtask

  task automatic test_eased_moves(int beats);
    int stop_at;
    stop_at = sent_beats + beats;
    while (sent_beats < stop_at) begin
      case ($urandom_range(0, 9))
        0: send_cmd(make_cmd(eti_pkg::func_t'($urandom_range(0, 3)), $urandom(), $urandom(),
                             $urandom(), 2'($urandom_range(0, 3))));
        1: send_cmd(make_cmd(eti_pkg::FUNC_SET, random_target(), $urandom(), $urandom(),
                             2'($urandom_range(0, 3))));
        default: random_move();
      endcase
    end
    wait_drained();
  endtask

  task automatic test_result_backlog();
    set_traffic(0, 0, BACKLOG_HOLD);
    repeat (3) random_move();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_eased_moves(480);
    set_traffic(51, 0, 0);
    test_eased_moves(480);
    set_traffic(0, 51, 0);
    test_eased_moves(480);
    set_traffic(38, 38, 0);
    test_eased_moves(480);
    test_result_backlog();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/eti_pkg.sv
src/eased_tween_interpolator_unit.sv
sim/testbench.sv
